### hdl/ucd_pkg.sv
// Shared widths, constants, reciprocal multipliers and types for the civil date converter.
`default_nettype none

package ucd_pkg;

  localparam int unsigned EPOCH_W  = 32;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned YEAR_W   = 12;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;

  localparam int unsigned SECS_PER_DAY    = 86400;
  localparam int unsigned SECS_PER_HOUR   = 3600;
  localparam int unsigned SECS_PER_MINUTE = 60;
  localparam int unsigned MINS_PER_HOUR   = 60;
  localparam int unsigned DAY_SHIFT       = 719468;
  localparam int unsigned DAYS_PER_ERA    = 146097;
  localparam int unsigned YEARS_PER_ERA   = 400;
  localparam int unsigned DAYS_PER_YEAR   = 365;

  // seconds split as {hi, lo}; SECS_PER_DAY is 675 << 7
  localparam int unsigned SEC_LO_W    = 7;
  localparam int unsigned SEC_HI_W    = EPOCH_W - SEC_LO_W;
  localparam int unsigned SEC_HI_DIV  = SECS_PER_DAY >> SEC_LO_W;
  localparam int unsigned DAYS_W      = 16;
  localparam int unsigned SEC_REM_W   = 17;
  localparam int unsigned REM_HI_W    = SEC_REM_W - SEC_LO_W;

  localparam int unsigned DOE_W  = 18;
  localparam int unsigned YOE_W  = 9;
  localparam int unsigned DOY_W  = 9;
  localparam int unsigned MP_W   = 4;
  localparam int unsigned Q60_W  = 11;

  localparam int unsigned ERA_LO     = DAY_SHIFT / DAYS_PER_ERA;
  localparam int unsigned ERA_SPLIT  = (ERA_LO + 1) * DAYS_PER_ERA - DAY_SHIFT;
  localparam int unsigned DOE_SHIFT  = DAY_SHIFT - ERA_LO * DAYS_PER_ERA;
  localparam int unsigned YEAR_LO    = ERA_LO * YEARS_PER_ERA;
  localparam int unsigned YEAR_HI    = (ERA_LO + 1) * YEARS_PER_ERA;

  localparam int unsigned CENT_1 = 36524;
  localparam int unsigned CENT_2 = 2 * CENT_1;
  localparam int unsigned CENT_3 = 3 * CENT_1;
  localparam int unsigned LAST_DOE = DAYS_PER_ERA - 1;
  localparam int unsigned QUAD_DAYS = 1460;

  localparam int unsigned MONTH_SHIFT = 3;
  localparam int unsigned MONTH_WRAP  = 9;
  localparam int unsigned MP_JAN      = 10;

  // floor(x / d) == (x * ceil(2^S / d)) >> S for the value range of x at each site
  localparam int unsigned S_DAY  = 35;
  localparam logic [25:0] M_DAY  = 26'(((64'd1 << S_DAY) + 64'(SEC_HI_DIV) - 64'd1)
                                      / 64'(SEC_HI_DIV));
  localparam int unsigned S_QUAD = 29;
  localparam logic [18:0] M_QUAD = 19'(((64'd1 << S_QUAD) + 64'(QUAD_DAYS) - 64'd1)
                                      / 64'(QUAD_DAYS));
  localparam int unsigned S_HOUR = 29;
  localparam logic [17:0] M_HOUR = 18'(((64'd1 << S_HOUR) + 64'(SECS_PER_HOUR) - 64'd1)
                                      / 64'(SECS_PER_HOUR));
  localparam int unsigned S_MIN  = 23;
  localparam logic [17:0] M_MIN  = 18'(((64'd1 << S_MIN) + 64'(SECS_PER_MINUTE) - 64'd1)
                                      / 64'(SECS_PER_MINUTE));
  localparam int unsigned S_YEAR = 27;
  localparam logic [18:0] M_YEAR = 19'(((64'd1 << S_YEAR) + 64'(DAYS_PER_YEAR) - 64'd1)
                                      / 64'(DAYS_PER_YEAR));
  localparam int unsigned S_CENT = 16;
  localparam logic [9:0]  M_CENT = 10'(((64'd1 << S_CENT) + 64'd99) / 64'd100);
  localparam int unsigned S_MON  = 19;
  localparam logic [11:0] M_MON  = 12'(((64'd1 << S_MON) + 64'd152) / 64'd153);

  typedef struct packed {
    logic [DOE_W-1:0]     doe;
    logic                 era_hi;
    logic [SEC_REM_W-1:0] sec_rem;
  } split_t;

  // first day of each March-based month within the year
  function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
    logic [DOY_W-1:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### hdl/ucd_if.sv
// Request and result channel interfaces of the civil date converter.
`default_nettype none

interface ucd_req_if;
  import ucd_pkg::*;
  logic               valid;
  logic               ready;
  logic [EPOCH_W-1:0] epoch_seconds;
  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface ucd_rsp_if;
  import ucd_pkg::*;
  logic                valid;
  logic                ready;
  logic [DAY_W-1:0]    day_of_month;
  logic [MONTH_W-1:0]  month_number;
  logic [YEAR_W-1:0]   year_number;
  logic [HOUR_W-1:0]   hour_of_day;
  logic [MINUTE_W-1:0] minute_of_hour;
  modport source (output valid, output day_of_month, output month_number,
                  output year_number, output hour_of_day, output minute_of_hour,
                  input ready);
  modport sink   (input valid, input day_of_month, input month_number,
                  input year_number, input hour_of_day, input minute_of_hour,
                  output ready);
endinterface

`default_nettype wire

### hdl/ucd_day_split.sv
// Two pipeline stages: split seconds into day count and second of day, place day in its era.
`default_nettype none

module ucd_day_split (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  logic [ucd_pkg::EPOCH_W-1:0]     epoch_seconds_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output ucd_pkg::split_t                 split_o
);
  import ucd_pkg::*;

  localparam int unsigned PROD_W = SEC_HI_W + 26;
  localparam int unsigned SCL_W  = DAYS_W + 10;

  logic                   a_v_q, b_v_q;
  logic                   en_a, en_b;
  logic [DAYS_W-1:0]      a_days_q;
  logic [SEC_HI_W-1:0]    a_hi_q;
  logic [SEC_LO_W-1:0]    a_lo_q;
  split_t                 b_split_q;

  logic [PROD_W-1:0]      a_prod;
  logic [SCL_W-1:0]       b_scaled;
  logic [SCL_W-1:0]       b_rem_hi;
  logic                   b_era_hi;
  logic [DOE_W-1:0]       b_doe;

  assign en_b    = !b_v_q || ready_i;
  assign en_a    = !a_v_q || en_b;
  assign ready_o = en_a;

  assign a_prod = PROD_W'(epoch_seconds_i[EPOCH_W-1:SEC_LO_W]) * PROD_W'(M_DAY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
    end else begin
      if (en_a) a_v_q <= valid_i;
      if (en_b) b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a && valid_i) begin
      a_days_q <= a_prod[S_DAY +: DAYS_W];
      a_hi_q   <= epoch_seconds_i[EPOCH_W-1:SEC_LO_W];
      a_lo_q   <= epoch_seconds_i[SEC_LO_W-1:0];
    end
  end

  always_comb begin
    b_scaled = SCL_W'(a_days_q) * SCL_W'(SEC_HI_DIV);
    b_rem_hi = SCL_W'(a_hi_q) - b_scaled;
    b_era_hi = (a_days_q >= DAYS_W'(ERA_SPLIT));
    b_doe    = b_era_hi ? (DOE_W'(a_days_q) - DOE_W'(ERA_SPLIT))
                        : (DOE_W'(a_days_q) + DOE_W'(DOE_SHIFT));
  end

  always_ff @(posedge clk_i) begin
    if (en_b && a_v_q) begin
      b_split_q.doe     <= b_doe;
      b_split_q.era_hi  <= b_era_hi;
      b_split_q.sec_rem <= {b_rem_hi[REM_HI_W-1:0], a_lo_q};
    end
  end

  assign valid_o = b_v_q;
  assign split_o = b_split_q;

endmodule

`default_nettype wire

### hdl/ucd_civil.sv
// Seven pipeline stages: day of era to year, month and day; second of day to hour and minute.
`default_nettype none

module ucd_civil (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  ucd_pkg::split_t               split_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [ucd_pkg::DAY_W-1:0]     day_of_month_o,
  output logic [ucd_pkg::MONTH_W-1:0]   month_number_o,
  output logic [ucd_pkg::YEAR_W-1:0]    year_number_o,
  output logic [ucd_pkg::HOUR_W-1:0]    hour_of_day_o,
  output logic [ucd_pkg::MINUTE_W-1:0]  minute_of_hour_o
);
  import ucd_pkg::*;

  localparam int unsigned NSTG = 7;

  logic [NSTG-1:0] v_q;
  logic [NSTG:0]   en;

  // stage C
  logic [DOE_W-1:0]    c_doe_q;
  logic                c_era_q;
  logic [6:0]          c_q1460_q;
  logic [2:0]          c_qcent_q;
  logic                c_qlast_q;
  logic [HOUR_W-1:0]   c_hour_q;
  logic [Q60_W-1:0]    c_q60_q;
  // stage D
  logic [DOE_W-1:0]    d_y_q, d_doe_q;
  logic                d_era_q;
  logic [HOUR_W-1:0]   d_hour_q;
  logic [MINUTE_W-1:0] d_min_q;
  // stage E
  logic [YOE_W-1:0]    e_yoe_q;
  logic [DOE_W-1:0]    e_doe_q;
  logic                e_era_q;
  logic [HOUR_W-1:0]   e_hour_q;
  logic [MINUTE_W-1:0] e_min_q;
  // stage F
  logic [DOE_W-1:0]    f_base_q, f_doe_q;
  logic [1:0]          f_c100_q;
  logic [YEAR_W-1:0]   f_year_q;
  logic [HOUR_W-1:0]   f_hour_q;
  logic [MINUTE_W-1:0] f_min_q;
  // stage G
  logic [DOY_W-1:0]    g_doy_q;
  logic [YEAR_W-1:0]   g_year_q;
  logic [HOUR_W-1:0]   g_hour_q;
  logic [MINUTE_W-1:0] g_min_q;
  // stage H
  logic [MP_W-1:0]     h_mp_q;
  logic [DOY_W-1:0]    h_doy_q;
  logic [YEAR_W-1:0]   h_year_q;
  logic [HOUR_W-1:0]   h_hour_q;
  logic [MINUTE_W-1:0] h_min_q;
  // stage I (output)
  logic [DAY_W-1:0]    i_day_q;
  logic [MONTH_W-1:0]  i_month_q;
  logic [YEAR_W-1:0]   i_year_q;
  logic [HOUR_W-1:0]   i_hour_q;
  logic [MINUTE_W-1:0] i_min_q;

  logic [36:0]         c_pquad;
  logic [33:0]         c_phour, c_pmin;
  logic [2:0]          c_qcent;
  logic [Q60_W-1:0]    d_min_full;
  logic [35:0]         e_pyear;
  logic [18:0]         f_pcent;
  logic [DOE_W-1:0]    f_base;
  logic [DOE_W-1:0]    g_doy_full;
  logic [10:0]         h_num;
  logic [22:0]         h_pmon;
  logic [DOY_W-1:0]    i_day_full;
  logic                i_jan_feb;

  always_comb begin
    en[NSTG] = ready_i;
    for (int k = NSTG - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // stage C: quotient by 1460, century count, hour and minute quotients
  always_comb begin
    c_pquad = 37'(split_i.doe) * 37'(M_QUAD);
    c_phour = 34'(split_i.sec_rem) * 34'(M_HOUR);
    c_pmin  = 34'(split_i.sec_rem) * 34'(M_MIN);
    c_qcent = 3'(split_i.doe >= DOE_W'(CENT_1)) + 3'(split_i.doe >= DOE_W'(CENT_2))
            + 3'(split_i.doe >= DOE_W'(CENT_3)) + 3'(split_i.doe >= DOE_W'(LAST_DOE));
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && valid_i) begin
      c_doe_q   <= split_i.doe;
      c_era_q   <= split_i.era_hi;
      c_q1460_q <= c_pquad[S_QUAD +: 7];
      c_qcent_q <= c_qcent;
      c_qlast_q <= (split_i.doe == DOE_W'(LAST_DOE));
      c_hour_q  <= c_phour[S_HOUR +: HOUR_W];
      c_q60_q   <= c_pmin[S_MIN +: Q60_W];
    end
  end

  // stage D: corrected day count for the year division, minute of hour
  assign d_min_full = c_q60_q - Q60_W'(c_hour_q) * Q60_W'(MINS_PER_HOUR);

  always_ff @(posedge clk_i) begin
    if (en[1] && v_q[0]) begin
      d_y_q    <= c_doe_q - DOE_W'(c_q1460_q) + DOE_W'(c_qcent_q) - DOE_W'(c_qlast_q);
      d_doe_q  <= c_doe_q;
      d_era_q  <= c_era_q;
      d_hour_q <= c_hour_q;
      d_min_q  <= d_min_full[MINUTE_W-1:0];
    end
  end

  // stage E: year of era
  assign e_pyear = 36'(d_y_q) * 36'(M_YEAR);

  always_ff @(posedge clk_i) begin
    if (en[2] && v_q[1]) begin
      e_yoe_q  <= e_pyear[S_YEAR +: YOE_W];
      e_doe_q  <= d_doe_q;
      e_era_q  <= d_era_q;
      e_hour_q <= d_hour_q;
      e_min_q  <= d_min_q;
    end
  end

  // stage F: days before the year, year number
  always_comb begin
    f_pcent = 19'(e_yoe_q) * 19'(M_CENT);
    f_base  = DOE_W'(e_yoe_q) * DOE_W'(DAYS_PER_YEAR) + DOE_W'(e_yoe_q >> 2);
  end

  always_ff @(posedge clk_i) begin
    if (en[3] && v_q[2]) begin
      f_base_q <= f_base;
      f_c100_q <= f_pcent[S_CENT +: 2];
      f_doe_q  <= e_doe_q;
      f_year_q <= YEAR_W'(e_yoe_q) + (e_era_q ? YEAR_W'(YEAR_HI) : YEAR_W'(YEAR_LO));
      f_hour_q <= e_hour_q;
      f_min_q  <= e_min_q;
    end
  end

  // stage G: day of year
  assign g_doy_full = f_doe_q - (f_base_q - DOE_W'(f_c100_q));

  always_ff @(posedge clk_i) begin
    if (en[4] && v_q[3]) begin
      g_doy_q  <= g_doy_full[DOY_W-1:0];
      g_year_q <= f_year_q;
      g_hour_q <= f_hour_q;
      g_min_q  <= f_min_q;
    end
  end

  // stage H: month counted from March
  always_comb begin
    h_num  = 11'(g_doy_q) * 11'd5 + 11'd2;
    h_pmon = 23'(h_num) * 23'(M_MON);
  end

  always_ff @(posedge clk_i) begin
    if (en[5] && v_q[4]) begin
      h_mp_q   <= h_pmon[S_MON +: MP_W];
      h_doy_q  <= g_doy_q;
      h_year_q <= g_year_q;
      h_hour_q <= g_hour_q;
      h_min_q  <= g_min_q;
    end
  end

  // stage I: day of month, calendar month, year rollover for January and February
  always_comb begin
    i_day_full = h_doy_q - month_start(h_mp_q) + DOY_W'(1);
    i_jan_feb  = (h_mp_q >= MP_W'(MP_JAN));
  end

  always_ff @(posedge clk_i) begin
    if (en[6] && v_q[5]) begin
      i_day_q   <= i_day_full[DAY_W-1:0];
      i_month_q <= i_jan_feb ? (h_mp_q - MONTH_W'(MONTH_WRAP))
                             : (h_mp_q + MONTH_W'(MONTH_SHIFT));
      i_year_q  <= h_year_q + YEAR_W'(i_jan_feb);
      i_hour_q  <= h_hour_q;
      i_min_q   <= h_min_q;
    end
  end

  assign valid_o          = v_q[NSTG-1];
  assign day_of_month_o   = i_day_q;
  assign month_number_o   = i_month_q;
  assign year_number_o    = i_year_q;
  assign hour_of_day_o    = i_hour_q;
  assign minute_of_hour_o = i_min_q;

endmodule

`default_nettype wire

### hdl/unix_time_to_civil_date.sv
// Top level of the Unix time to civil date and time of day converter.
// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00 UTC into the Gregorian
// day, month (1 = January) and year, plus hour and minute; seconds are dropped. The block is
// a nine-stage pipeline with valid bits in every stage: it takes one request per clock cycle
// while the result channel does not stall and returns each result from its last stage. All
// divisions are by constants and are done as reciprocal multiplies, shifts or compares; the
// pipeline depth is set by the chain day split, era, year, day of year, month. Each stage
// holds its item under backpressure and fills empty slots, so a stalled result does not
// block new requests until every stage is full.
`default_nettype none

module unix_time_to_civil_date (
  input  logic   clk_i,
  input  logic   rst_ni,
  ucd_req_if.sink   req_i,
  ucd_rsp_if.source rsp_o
);
  import ucd_pkg::*;

  logic   mid_valid;
  logic   mid_ready;
  split_t mid_split;

  ucd_day_split u_day_split (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (req_i.valid),
    .ready_o         (req_i.ready),
    .epoch_seconds_i (req_i.epoch_seconds),
    .valid_o         (mid_valid),
    .ready_i         (mid_ready),
    .split_o         (mid_split)
  );

  ucd_civil u_civil (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (mid_valid),
    .ready_o          (mid_ready),
    .split_i          (mid_split),
    .valid_o          (rsp_o.valid),
    .ready_i          (rsp_o.ready),
    .day_of_month_o   (rsp_o.day_of_month),
    .month_number_o   (rsp_o.month_number),
    .year_number_o    (rsp_o.year_number),
    .hour_of_day_o    (rsp_o.hour_of_day),
    .minute_of_hour_o (rsp_o.minute_of_hour)
  );

endmodule

`default_nettype wire
